// ----- hw/rtl/mmdb_pkg.sv -----
package mmdb_pkg;

	// Fixed field widths.
	localparam int SMP_W  = 32;
	localparam int NSMP   = 8;
	localparam int DLY_W  = 11;
	localparam int CH_W   = 4;
	localparam int LANE_W = 2;
	localparam int ST_W   = 3;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = DLY_W;
	localparam int NUM_LANE_REGS = 4;

	// Default sizes.
	localparam int DEF_LANES        = 4;
	localparam int DEF_MAX_CHANNELS = 8;
	localparam int DEF_MAX_DELAY    = 1024;
	localparam int DEF_MAX_FRAMES   = 32;

	// Register map: delays first, then channel counts.
	localparam logic [CFG_IDX_W-1:0] CFG_DELAY_BASE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CHANS_BASE = 3'd4;

	// Opcodes.
	localparam logic OP_FRAME = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	// Result status codes.
	localparam logic [ST_W-1:0] ST_OK         = 3'd0;
	localparam logic [ST_W-1:0] ST_UNPREPARED = 3'd1;
	localparam logic [ST_W-1:0] ST_MISMATCH   = 3'd2;
	localparam logic [ST_W-1:0] ST_TOO_MANY   = 3'd3;
	localparam logic [ST_W-1:0] ST_NONFINITE  = 3'd4;
	localparam logic [ST_W-1:0] ST_CLEARED    = 3'd5;

	// Exponent field of a single-precision pattern.
	localparam logic [SMP_W-1:0] EXP_MASK = 32'h7F80_0000;

endpackage

// ----- hw/rtl/mmdb_if.sv -----
interface mmdb_frame_if;
	logic valid;
	logic ready;
	logic opcode;
	logic [mmdb_pkg::LANE_W-1:0] lane;
	logic [mmdb_pkg::CH_W-1:0] frame_channels;
	logic last_frame;
	logic [mmdb_pkg::SMP_W-1:0] sample_in0;
	logic [mmdb_pkg::SMP_W-1:0] sample_in1;
	logic [mmdb_pkg::SMP_W-1:0] sample_in2;
	logic [mmdb_pkg::SMP_W-1:0] sample_in3;
	logic [mmdb_pkg::SMP_W-1:0] sample_in4;
	logic [mmdb_pkg::SMP_W-1:0] sample_in5;
	logic [mmdb_pkg::SMP_W-1:0] sample_in6;
	logic [mmdb_pkg::SMP_W-1:0] sample_in7;

	modport source (output valid, opcode, lane, frame_channels, last_frame,
		sample_in0, sample_in1, sample_in2, sample_in3,
		sample_in4, sample_in5, sample_in6, sample_in7, input ready);
	modport sink (input valid, opcode, lane, frame_channels, last_frame,
		sample_in0, sample_in1, sample_in2, sample_in3,
		sample_in4, sample_in5, sample_in6, sample_in7, output ready);
endinterface

interface mmdb_result_if;
	logic valid;
	logic ready;
	logic [mmdb_pkg::SMP_W-1:0] sample_out0;
	logic [mmdb_pkg::SMP_W-1:0] sample_out1;
	logic [mmdb_pkg::SMP_W-1:0] sample_out2;
	logic [mmdb_pkg::SMP_W-1:0] sample_out3;
	logic [mmdb_pkg::SMP_W-1:0] sample_out4;
	logic [mmdb_pkg::SMP_W-1:0] sample_out5;
	logic [mmdb_pkg::SMP_W-1:0] sample_out6;
	logic [mmdb_pkg::SMP_W-1:0] sample_out7;
	logic [mmdb_pkg::ST_W-1:0] status;
	logic last_out;

	modport source (output valid, sample_out0, sample_out1, sample_out2,
		sample_out3, sample_out4, sample_out5, sample_out6, sample_out7,
		status, last_out, input ready);
	modport sink (input valid, sample_out0, sample_out1, sample_out2,
		sample_out3, sample_out4, sample_out5, sample_out6, sample_out7,
		status, last_out, output ready);
endinterface

// ----- hw/rtl/multilane_multichannel_delay_bank_unit.sv -----
// Channel   Dir  Handshake      Beat
// frame     in   valid/ready    one audio frame or a clear command
// result    out  valid/ready    one delayed frame or one status word
// cfg       in   cfg_we only    one register write, taken at once
//
// A frame that is not the last of its block is stored in the block store. A block
// end first runs the checks, then releases each frame with a ring read and then
// a write back, set by the single port pair of the ring memory.
// After reset, a register write or a clear command the ring memory is swept,
// one row a cycle, all LANES*MAX_DELAY rows (4096 by default); a non-finite
// flush sweeps one lane, MAX_DELAY rows. No frame is taken while sweeping.
// The result register stalls the release when the sink holds ready low.
module multilane_multichannel_delay_bank_unit #(
	parameter int LANES        = mmdb_pkg::DEF_LANES,
	parameter int MAX_CHANNELS = mmdb_pkg::DEF_MAX_CHANNELS,
	parameter int MAX_DELAY    = mmdb_pkg::DEF_MAX_DELAY,
	parameter int MAX_FRAMES   = mmdb_pkg::DEF_MAX_FRAMES
) (
	input  logic clk,
	input  logic arst_n,
	mmdb_frame_if.sink frame,
	mmdb_result_if.source result,
	input  logic cfg_we,
	input  logic [mmdb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mmdb_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int RING_DEPTH = LANES * MAX_DELAY;
	localparam int RA_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int POS_W = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
	localparam int SI_W  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int FC_W  = $clog2(MAX_FRAMES + 2);
	localparam int LN_W  = (LANES > 1) ? $clog2(LANES) : 1;
	localparam int ROW_W = MAX_CHANNELS * mmdb_pkg::SMP_W;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_FIN  = 5'b00010,
		S_RD   = 5'b00100,
		S_WR   = 5'b01000,
		S_CLO  = 5'b10000
	} state_t;

	typedef logic [MAX_CHANNELS-1:0][mmdb_pkg::SMP_W-1:0] row_t;

	state_t state_q;

	// Configuration registers.
	logic [mmdb_pkg::NUM_LANE_REGS-1:0][mmdb_pkg::DLY_W-1:0] delay_q;
	logic [mmdb_pkg::NUM_LANE_REGS-1:0][mmdb_pkg::CH_W-1:0] chans_q;

	// Block bookkeeping.
	logic [FC_W-1:0] frames_q;
	logic [mmdb_pkg::LANE_W-1:0] blane_q;
	logic [mmdb_pkg::CH_W-1:0] bwidth_q;
	logic nf_q;
	logic [LANES-1:0][POS_W-1:0] ring_pos_q;

	// Release loop.
	logic [FC_W-1:0] f_q;
	logic [POS_W-1:0] pos_q;

	// Sweep of the ring memory.
	logic sweep_q;
	logic [RA_W-1:0] sweep_addr_q;
	logic [RA_W-1:0] sweep_end_q;

	// Memories.
	row_t ring_mem [RING_DEPTH];
	row_t store_mem [MAX_FRAMES];
	row_t ring_rd_q;
	row_t store_rd_q;

	// Result register.
	logic out_valid_q;
	logic [mmdb_pkg::NSMP-1:0][mmdb_pkg::SMP_W-1:0] out_smp_q;
	logic [mmdb_pkg::ST_W-1:0] out_status_q;
	logic out_last_q;

	logic [mmdb_pkg::NSMP-1:0][mmdb_pkg::SMP_W-1:0] smp_in;
	row_t in_row;
	logic accept;
	logic out_free;
	logic first;
	logic [mmdb_pkg::CH_W-1:0] width_e;
	logic nf_in;
	logic [mmdb_pkg::ST_W-1:0] fin_status;
	logic [mmdb_pkg::DLY_W-1:0] cur_delay;
	logic [mmdb_pkg::CH_W-1:0] cur_chans;
	logic [POS_W-1:0] cur_rpos;
	logic [RA_W-1:0] lane_base;
	logic [RA_W-1:0] ring_addr;
	logic [POS_W:0] pos_inc;
	logic [POS_W-1:0] pos_next;
	logic last_rel;
	row_t rel_row;
	row_t wb_row;
	logic ring_we;
	logic [RA_W-1:0] ring_wa;
	row_t ring_wd;

	assign smp_in = {frame.sample_in7, frame.sample_in6, frame.sample_in5,
		frame.sample_in4, frame.sample_in3, frame.sample_in2, frame.sample_in1,
		frame.sample_in0};

	assign frame.ready = (state_q == S_IDLE) && !sweep_q;
	assign accept = frame.valid && frame.ready;
	assign out_free = !out_valid_q || result.ready;

	// Block attributes of the incoming frame and its non-finite check.
	always_comb begin
		first = (frames_q == '0);
		width_e = first ? frame.frame_channels : bwidth_q;
		nf_in = 1'b0;
		for (int c = 0; c < MAX_CHANNELS; c++) begin
			in_row[c] = smp_in[c];
			if (c < 32'(width_e) &&
				(smp_in[c] & mmdb_pkg::EXP_MASK) == mmdb_pkg::EXP_MASK) begin
				nf_in = 1'b1;
			end
		end
	end

	// Settings of the block's lane.
	always_comb begin
		cur_delay = delay_q[blane_q];
		cur_chans = chans_q[blane_q];
		cur_rpos = ring_pos_q[blane_q[LN_W-1:0]];
		lane_base = RA_W'(RA_W'(blane_q) * RA_W'(MAX_DELAY));
		ring_addr = RA_W'(lane_base + RA_W'(pos_q));
	end

	// Block-end checks, in priority order.
	always_comb begin
		if (32'(frames_q) > MAX_FRAMES) begin
			fin_status = mmdb_pkg::ST_TOO_MANY;
		end else if (32'(blane_q) >= LANES || cur_chans == '0 ||
			32'(cur_chans) > MAX_CHANNELS || 32'(cur_delay) > MAX_DELAY) begin
			fin_status = mmdb_pkg::ST_UNPREPARED;
		end else if (bwidth_q != cur_chans) begin
			fin_status = mmdb_pkg::ST_MISMATCH;
		end else if (nf_q) begin
			fin_status = mmdb_pkg::ST_NONFINITE;
		end else begin
			fin_status = mmdb_pkg::ST_OK;
		end
	end

	// Release datapath: delayed or passed-through samples, ring write-back.
	always_comb begin
		pos_inc = {1'b0, pos_q} + 1'b1;
		pos_next = (32'(pos_inc) >= 32'(cur_delay)) ? '0 : pos_inc[POS_W-1:0];
		last_rel = (f_q == FC_W'(frames_q - 1'b1));
		for (int c = 0; c < MAX_CHANNELS; c++) begin
			if (c < 32'(cur_chans)) begin
				wb_row[c] = store_rd_q[c];
				rel_row[c] = (cur_delay == '0) ? store_rd_q[c] : ring_rd_q[c];
			end else begin
				wb_row[c] = '0;
				rel_row[c] = '0;
			end
		end
	end

	// Ring memory write port: sweep or release write-back.
	always_comb begin
		ring_we = 1'b0;
		ring_wa = ring_addr;
		ring_wd = wb_row;
		if (sweep_q) begin
			ring_we = 1'b1;
			ring_wa = sweep_addr_q;
			ring_wd = '0;
		end else if (state_q == S_WR && out_free && cur_delay != '0) begin
			ring_we = 1'b1;
		end
	end

	// Ring memory.
	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring_mem[ring_wa] <= ring_wd;
		end
		if (state_q == S_RD) begin
			ring_rd_q <= ring_mem[ring_addr];
		end
	end

	// Block store memory: one row per frame.
	always_ff @(posedge clk) begin
		if (accept && frame.opcode == mmdb_pkg::OP_FRAME &&
			32'(frames_q) < MAX_FRAMES) begin
			store_mem[frames_q[SI_W-1:0]] <= in_row;
		end
		if (state_q == S_RD) begin
			store_rd_q <= store_mem[f_q[SI_W-1:0]];
		end
	end

	// Control, bookkeeping and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			delay_q <= '0;
			chans_q <= '0;
			frames_q <= '0;
			blane_q <= '0;
			bwidth_q <= '0;
			nf_q <= 1'b0;
			ring_pos_q <= '0;
			f_q <= '0;
			pos_q <= '0;
			sweep_q <= 1'b1;
			sweep_addr_q <= '0;
			sweep_end_q <= RA_W'(RING_DEPTH - 1);
			out_valid_q <= 1'b0;
			out_smp_q <= '0;
			out_status_q <= '0;
			out_last_q <= 1'b0;
		end else begin
			if (out_valid_q && result.ready) begin
				out_valid_q <= 1'b0;
			end

			// Sweep advance.
			if (sweep_q) begin
				if (sweep_addr_q == sweep_end_q) begin
					sweep_q <= 1'b0;
				end else begin
					sweep_addr_q <= RA_W'(sweep_addr_q + 1'b1);
				end
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (frame.opcode == mmdb_pkg::OP_CLEAR) begin
							frames_q <= '0;
							blane_q <= '0;
							bwidth_q <= '0;
							nf_q <= 1'b0;
							ring_pos_q <= '0;
							sweep_q <= 1'b1;
							sweep_addr_q <= '0;
							sweep_end_q <= RA_W'(RING_DEPTH - 1);
							state_q <= S_CLO;
						end else begin
							if (first) begin
								blane_q <= frame.lane;
								bwidth_q <= frame.frame_channels;
							end
							if (32'(frames_q) < MAX_FRAMES) begin
								nf_q <= (first ? 1'b0 : nf_q) | nf_in;
								frames_q <= FC_W'(frames_q + 1'b1);
							end else begin
								nf_q <= first ? 1'b0 : nf_q;
								frames_q <= FC_W'(MAX_FRAMES + 1);
							end
							if (frame.last_frame) begin
								state_q <= S_FIN;
							end
						end
					end
				end
				S_FIN: begin
					if (out_free) begin
						if (fin_status != mmdb_pkg::ST_OK) begin
							out_valid_q <= 1'b1;
							out_smp_q <= '0;
							out_status_q <= fin_status;
							out_last_q <= 1'b1;
							if (fin_status == mmdb_pkg::ST_NONFINITE) begin
								ring_pos_q[blane_q[LN_W-1:0]] <= '0;
								sweep_q <= 1'b1;
								sweep_addr_q <= lane_base;
								sweep_end_q <= RA_W'(lane_base + RA_W'(MAX_DELAY - 1));
							end
							frames_q <= '0;
							blane_q <= '0;
							bwidth_q <= '0;
							nf_q <= 1'b0;
							state_q <= S_IDLE;
						end else begin
							f_q <= '0;
							pos_q <= (cur_delay != '0 && 32'(cur_rpos) >= 32'(cur_delay))
								? '0 : cur_rpos;
							state_q <= S_RD;
						end
					end
				end
				S_RD: begin
					state_q <= S_WR;
				end
				S_WR: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_smp_q <= '0;
						for (int c = 0; c < MAX_CHANNELS; c++) begin
							out_smp_q[c] <= rel_row[c];
						end
						out_status_q <= mmdb_pkg::ST_OK;
						out_last_q <= last_rel;
						f_q <= FC_W'(f_q + 1'b1);
						if (cur_delay != '0) begin
							pos_q <= pos_next;
						end
						if (last_rel) begin
							ring_pos_q[blane_q[LN_W-1:0]] <=
								(cur_delay != '0) ? pos_next : pos_q;
							frames_q <= '0;
							blane_q <= '0;
							bwidth_q <= '0;
							nf_q <= 1'b0;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				S_CLO: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_smp_q <= '0;
						out_status_q <= mmdb_pkg::ST_CLEARED;
						out_last_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			// Register writes; any write restarts a full ring sweep.
			if (cfg_we) begin
				if (cfg_index < mmdb_pkg::CFG_CHANS_BASE) begin
					delay_q[cfg_index[1:0]] <= cfg_data;
				end else begin
					chans_q[cfg_index[1:0]] <= cfg_data[mmdb_pkg::CH_W-1:0];
				end
				ring_pos_q <= '0;
				sweep_q <= 1'b1;
				sweep_addr_q <= '0;
				sweep_end_q <= RA_W'(RING_DEPTH - 1);
			end
		end
	end

	assign result.valid = out_valid_q;
	assign result.sample_out0 = out_smp_q[0];
	assign result.sample_out1 = out_smp_q[1];
	assign result.sample_out2 = out_smp_q[2];
	assign result.sample_out3 = out_smp_q[3];
	assign result.sample_out4 = out_smp_q[4];
	assign result.sample_out5 = out_smp_q[5];
	assign result.sample_out6 = out_smp_q[6];
	assign result.sample_out7 = out_smp_q[7];
	assign result.status = out_status_q;
	assign result.last_out = out_last_q;

endmodule

// ----- sim/tb_multilane_multichannel_delay_bank_unit.sv -----
`timescale 1ns / 1ps

import mmdb_pkg::*;

typedef struct {
	logic                  opcode;
	logic [LANE_W-1:0]     lane;
	logic [CH_W-1:0]       fch;
	logic                  last;
	logic [NSMP-1:0][SMP_W-1:0] smp;
} frame_beat_t;

typedef struct {
	logic [NSMP-1:0][SMP_W-1:0] smp;
	logic [ST_W-1:0]       st;
	logic                  last;
} delayed_beat_t;

// Tracks the delay bank state and the delayed beats it must release.
class delay_bank_scoreboard;
	localparam int LN = DEF_LANES;
	localparam int MCH = DEF_MAX_CHANNELS;
	localparam int MDL = DEF_MAX_DELAY;
	localparam int MFR = DEF_MAX_FRAMES;

	logic [SMP_W-1:0] ring [LN*MCH*MDL];
	int unsigned      wpos [LN];
	logic [SMP_W-1:0] held [MFR*MCH];
	int unsigned      held_frames, held_lane, held_width;
	bit               saw_nonfinite;
	int unsigned      dly [LN];
	int unsigned      chn [LN];
	delayed_beat_t    pending_beats[$];
	int unsigned      mismatches, released, status_seen [8];

	function void clear_rings();
		foreach (ring[i]) ring[i] = '0;
		foreach (wpos[i]) wpos[i] = 0;
	endfunction

	function void end_block();
		held_frames = 0;
		held_lane = 0;
		held_width = 0;
		saw_nonfinite = 0;
	endfunction

	function void reset_all();
		clear_rings();
		end_block();
		foreach (dly[i]) dly[i] = 0;
		foreach (chn[i]) chn[i] = 0;
		mismatches = 0;
		released = 0;
	endfunction

	function void write_reg(int unsigned idx, int unsigned val);
		if (idx < CFG_CHANS_BASE) dly[idx] = val & 'h7FF;
		else chn[idx - CFG_CHANS_BASE] = val & 'hF;
		clear_rings();
	endfunction

	function void push_status(logic [ST_W-1:0] st);
		delayed_beat_t b;
		b.smp = '0;
		b.st = st;
		b.last = 1'b1;
		pending_beats.push_back(b);
	endfunction

	// Predict what one accepted frame beat causes.
	function void note_beat(frame_beat_t fb);
		int unsigned w, ln, d, pos, idx;
		logic [ST_W-1:0] st;
		delayed_beat_t b;
		if (fb.opcode == OP_CLEAR) begin
			clear_rings();
			end_block();
			push_status(ST_CLEARED);
			return;
		end
		if (held_frames == 0) begin
			held_lane = fb.lane;
			held_width = fb.fch;
			saw_nonfinite = 0;
		end
		w = (held_width > MCH) ? MCH : held_width;
		if (held_frames < MFR) begin
			for (int c = 0; c < w; c++) begin
				held[held_frames*MCH + c] = fb.smp[c];
				if ((fb.smp[c] & EXP_MASK) == EXP_MASK) saw_nonfinite = 1;
			end
			held_frames++;
		end else begin
			held_frames = MFR + 1;
		end
		if (!fb.last) return;

		ln = held_lane;
		st = ST_OK;
		if (held_frames > MFR) st = ST_TOO_MANY;
		else if (ln >= LN || chn[ln] == 0 || chn[ln] > MCH || dly[ln] > MDL)
			st = ST_UNPREPARED;
		else if (held_width != chn[ln]) st = ST_MISMATCH;
		else if (saw_nonfinite) begin
			for (int i = ln*MCH*MDL; i < (ln+1)*MCH*MDL; i++) ring[i] = '0;
			wpos[ln] = 0;
			st = ST_NONFINITE;
		end
		if (st != ST_OK) begin
			end_block();
			push_status(st);
			return;
		end

		// Release: swap each sample with the ring entry at the write position, or pass it through when the delay is zero.
		d = dly[ln];
		pos = wpos[ln];
		if (d != 0 && pos >= d) pos = 0;
		for (int f = 0; f < held_frames; f++) begin
			b.smp = '0;
			for (int c = 0; c < chn[ln]; c++) begin
				if (d == 0) begin
					b.smp[c] = held[f*MCH + c];
				end else begin
					idx = (ln*MCH + c)*MDL + pos;
					b.smp[c] = ring[idx];
					ring[idx] = held[f*MCH + c];
				end
			end
			if (d != 0) begin
				pos++;
				if (pos >= d) pos = 0;
			end
			b.st = ST_OK;
			b.last = (f + 1 == held_frames);
			pending_beats.push_back(b);
		end
		wpos[ln] = pos;
		end_block();
	endfunction

	function void check_beat(delayed_beat_t got);
		delayed_beat_t exp_b;
		released++;
		status_seen[got.st]++;
		if (pending_beats.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: unexpected result beat, status %0d", $realtime, got.st);
			return;
		end
		exp_b = pending_beats.pop_front();
		if (got.smp !== exp_b.smp || got.st !== exp_b.st || got.last !== exp_b.last) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("%0t: result beat mismatch", $realtime);
				$display("  expected status %0d last %0d samples %h", exp_b.st,
					exp_b.last, exp_b.smp);
				$display("  actual   status %0d last %0d samples %h", got.st,
					got.last, got.smp);
			end
		end
	endfunction
endclass

module tb_multilane_multichannel_delay_bank_unit;
	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	bit quiet;
	int unsigned stall_left;
	int unsigned beats_sent;
	delay_bank_scoreboard sb;

	mmdb_frame_if fr();
	mmdb_result_if rs();

	multilane_multichannel_delay_bank_unit dut (
		.clk(clk), .arst_n(arst_n), .frame(fr), .result(rs),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// Result side: random stall bursts, none during the quiet tail.
	always @(posedge clk) begin
		delayed_beat_t got;
		if (rs.valid === 1'b1 && rs.ready === 1'b1) begin
			got.smp = {rs.sample_out7, rs.sample_out6, rs.sample_out5, rs.sample_out4,
				rs.sample_out3, rs.sample_out2, rs.sample_out1, rs.sample_out0};
			got.st = rs.status;
			got.last = rs.last_out;
			sb.check_beat(got);
		end
		if (quiet) begin
			rs.ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			rs.ready <= 1'b0;
		end else if ($urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(0, 11);
			rs.ready <= 1'b0;
		end else begin
			rs.ready <= 1'b1;
		end
	end

	task automatic write_reg(int unsigned idx, int unsigned val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_IDX_W'(idx);
		cfg_data <= CFG_DATA_W'(val);
		sb.write_reg(idx, val);
		@(posedge clk);
		cfg_we <= 1'b0;
		// Let the ring sweep that follows a write run out.
		repeat (4200) @(posedge clk);
	endtask

	// Present one beat; valid stays high after acceptance unless a gap follows.
	task automatic send_beat(frame_beat_t fb);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			fr.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		fr.valid <= 1'b1;
		fr.opcode <= fb.opcode;
		fr.lane <= fb.lane;
		fr.frame_channels <= fb.fch;
		fr.last_frame <= fb.last;
		{fr.sample_in7, fr.sample_in6, fr.sample_in5, fr.sample_in4,
			fr.sample_in3, fr.sample_in2, fr.sample_in1, fr.sample_in0} <= fb.smp;
		@(posedge clk);
		while (fr.ready !== 1'b1) @(posedge clk);
		sb.note_beat(fb);
		beats_sent++;
	endtask

	function automatic frame_beat_t make_frame(int unsigned ln, int unsigned fch, bit last);
		frame_beat_t fb;
		fb.opcode = OP_FRAME;
		fb.lane = LANE_W'(ln);
		fb.fch = CH_W'(fch);
		fb.last = last;
		for (int c = 0; c < NSMP; c++) fb.smp[c] = $urandom();
		return fb;
	endfunction

	function automatic frame_beat_t make_clear();
		frame_beat_t fb;
		fb = make_frame($urandom_range(0, 3), $urandom_range(0, 15),
			1'($urandom_range(0, 1)));
		fb.opcode = OP_CLEAR;
		return fb;
	endfunction

	// A block of n frames; later frames carry random lane and width fields.
	task automatic send_block(int unsigned ln, int unsigned fch, int unsigned n,
			bit finite, bit inject_bad);
		frame_beat_t fb;
		int unsigned bad_f;
		bad_f = $urandom_range(0, n - 1);
		for (int f = 0; f < n; f++) begin
			fb = make_frame(ln, fch, f == n - 1);
			if (f != 0) begin
				fb.lane = LANE_W'($urandom_range(0, 3));
				fb.fch = CH_W'($urandom_range(0, 15));
			end
			if (finite)
				for (int c = 0; c < NSMP; c++)
					if ((fb.smp[c] & EXP_MASK) == EXP_MASK) fb.smp[c][30] = 1'b0;
			if (inject_bad && f == bad_f)
				fb.smp[$urandom_range(0, fch > 0 && fch <= 8 ? fch - 1 : 0)] =
					{$urandom_range(0, 1) == 1, 8'hFF, 23'($urandom_range(0, 3))};
			send_beat(fb);
		end
	endtask

	task automatic drain();
		fr.valid <= 1'b0;
		while (sb.pending_beats.size() != 0) @(posedge clk);
	endtask

	task automatic program_bank(int unsigned d0, d1, d2, d3, c0, c1, c2, c3);
		drain();
		repeat (4200) @(posedge clk);
		write_reg(CFG_DELAY_BASE + 0, d0);
		write_reg(CFG_DELAY_BASE + 1, d1);
		write_reg(CFG_DELAY_BASE + 2, d2);
		write_reg(CFG_DELAY_BASE + 3, d3);
		write_reg(CFG_CHANS_BASE + 0, c0);
		write_reg(CFG_CHANS_BASE + 1, c1);
		write_reg(CFG_CHANS_BASE + 2, c2);
		write_reg(CFG_CHANS_BASE + 3, c3);
	endtask

	// Random mix: mostly well-formed blocks, some broken ones and clears.
	task automatic random_traffic(int unsigned count);
		int unsigned stop_at, r, ln, n;
		frame_beat_t fb;
		stop_at = beats_sent + count;
		while (beats_sent < stop_at) begin
			r = $urandom_range(0, 99);
			ln = $urandom_range(0, 3);
			if (r < 5) begin
				send_beat(make_clear());
			end else if (r < 10) begin
				send_block(ln, sb.chn[ln], $urandom_range(33, 34), 1, 0);
			end else if (r < 20) begin
				n = $urandom_range(1, 4);
				if ($urandom_range(0, 2) == 0) begin
					for (int f = 0; f < n; f++) begin
						fb = make_frame($urandom_range(0, 3), $urandom_range(0, 15), 0);
						send_beat(fb);
					end
					send_beat(make_clear());
				end else begin
					send_block(ln, $urandom_range(0, 15), n, 0, 0);
				end
			end else begin
				for (int k = 0; k < 4; k++)
					if (sb.chn[ln] == 0 || sb.chn[ln] > 8) ln = (ln + 1) % 4;
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 32) : $urandom_range(1, 6);
				send_block(ln, sb.chn[ln], n, 1, $urandom_range(0, 24) == 0);
			end
		end
	endtask

	initial begin
		frame_beat_t fb;
		sb = new();
		sb.reset_all();
		arst_n = 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		fr.valid <= 1'b0;
		fr.opcode <= OP_FRAME;
		fr.lane <= '0;
		fr.frame_channels <= '0;
		fr.last_frame <= 1'b0;
		{fr.sample_in7, fr.sample_in6, fr.sample_in5, fr.sample_in4,
			fr.sample_in3, fr.sample_in2, fr.sample_in1, fr.sample_in0} <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Nothing prepared yet: a frame is refused, a clear is answered.
		send_block(0, 8, 1, 1, 0);
		send_beat(make_clear());

		program_bank(0, 1, 3, 1024, 8, 1, 4, 2);
		// Pass-through with extreme sample patterns.
		fb = make_frame(0, 8, 0);
		fb.smp = '0;
		send_beat(fb);
		fb = make_frame(0, 8, 1);
		for (int c = 0; c < NSMP; c++) fb.smp[c] = 32'hFF7F_FFFF;
		send_beat(fb);
		send_block(1, 1, 3, 1, 0);
		send_block(1, 1, 2, 1, 0);
		send_block(3, 2, 2, 1, 0);
		// Width mismatch, zero width, oversize width.
		send_block(2, 3, 2, 1, 0);
		send_block(2, 0, 1, 1, 0);
		send_block(2, 15, 1, 1, 0);
		// Infinity flushes the lane; a NaN does too.
		fb = make_frame(3, 2, 1);
		fb.smp[1] = 32'h7F80_0000;
		send_beat(fb);
		fb = make_frame(2, 4, 1);
		fb.smp[0] = 32'hFFC0_0001;
		send_beat(fb);
		send_block(2, 4, 3, 1, 0);
		// Clear in the middle of a block discards it.
		send_beat(make_frame(1, 1, 0));
		send_beat(make_clear());
		send_block(1, 1, 2, 1, 0);

		random_traffic(60);
		program_bank(2047, 5, 0, 2, 3, 15, 9, 8);
		random_traffic(60);
		program_bank($urandom_range(1, 8), 1024, $urandom_range(0, 4), 1025,
			$urandom_range(1, 8), 8, $urandom_range(1, 8), 1);
		random_traffic(60);
		program_bank(1, $urandom_range(0, 6), 2, 0,
			2, $urandom_range(1, 8), 6, $urandom_range(1, 8));
		quiet = 1;
		random_traffic(60);

		drain();
		repeat (200) @(posedge clk);
		$display("Sent %0d frame beats over five register settings; checked %0d result beats.",
			beats_sent, sb.released);
		$display("Status counts ok/unprep/mismatch/toomany/flush/clear: %0d %0d %0d %0d %0d %0d",
			sb.status_seen[0], sb.status_seen[1], sb.status_seen[2],
			sb.status_seen[3], sb.status_seen[4], sb.status_seen[5]);
		if (sb.mismatches == 0 && sb.pending_beats.size() == 0) begin
			$display("[multilane_multichannel_delay_bank_unit] OK");
		end else begin
			$display("[multilane_multichannel_delay_bank_unit] ERROR");
		end
		$finish;
	end

	// Watchdog.
	initial begin
		#4_000_000;
		$display("[multilane_multichannel_delay_bank_unit] ERROR");
		$finish;
	end
endmodule
